FILE: rtl/ohat_pkg.sv
// ============================================================================
// ohat_pkg
// Shared constants for the open-addressing hash table: request, status and
// slot mark codes, configuration register indexes and default sizes.
// ============================================================================
package ohat_pkg;

    localparam int DEF_SLOTS    = 1024;
    localparam int DEF_KEY_BITS = 32;

    localparam int REQ_BITS    = 2;
    localparam int KEY_W       = 32;
    localparam int PAY_BITS    = 64;
    localparam int STATUS_BITS = 2;
    localparam int SLOT_BITS   = 10;
    localparam int COUNT_BITS  = 11;
    localparam int MARK_BITS   = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [REQ_BITS-1:0] REQ_FIND    = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE  = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    localparam logic [MARK_BITS-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_BITS-1:0] MARK_FULL    = 2'd1;
    localparam logic [MARK_BITS-1:0] MARK_DELETED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] TABLE_SIZE_RESET = 11'd1021;
    localparam logic [31:0]           GOLDEN_FRAC      = 32'h9E37_79B9;

endpackage

FILE: rtl/ohat_ram.sv
// ============================================================================
// ohat_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module ohat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ohat_rem.sv
// ============================================================================
// ohat_rem
// Iterative remainder unit: key mod size, one restoring step per cycle.
// ============================================================================
module ohat_rem #(
    parameter int KEY_BITS = 32,
    parameter int SW       = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [KEY_BITS-1:0] dividend,
    input  logic [SW-1:0]       divisor,
    output logic                done,
    output logic [SW-1:0]       rem
);

    localparam int CW = $clog2(KEY_BITS + 1);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [KEY_BITS-1:0] dvd_reg, dvd_next;
    logic [SW-1:0]       rem_reg, rem_next;
    logic [SW-1:0]       dsr_reg, dsr_next;
    logic [SW:0]         trial;

    assign trial = {rem_reg, dvd_reg[KEY_BITS-1]};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CW'(KEY_BITS);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (run_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = SW'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = SW'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

`ifndef NO_ASSERTIONS
    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(run_reg)) else $error("remainder done without a run");
    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < dsr_reg)) else $error("remainder not below divisor");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> !start) else $error("remainder restarted while busy");
`endif

endmodule

FILE: rtl/open_addressing_hash_table_unit.sv
// ============================================================================
// open_addressing_hash_table_unit
// Open-addressing key/value store with division or multiplicative hashing
// and linear or quadratic probing over a single slot RAM.
// ============================================================================
// Requests arrive as beats on the s_ channel (request type, key, payload) and
// each one yields exactly one result beat on the m_ channel (status, payload,
// slot, count of full slots). The user must write the configuration port
// only while the block is idle; the block itself does not enforce this.
// After reset the block sweeps the slot RAM, marking every slot empty;
// s_ready stays low during the sweep.
// A request is taken in, then hashed by division (the iterative remainder
// unit) or by the multiplicative hash; each probe then reads the RAM and
// compares, an insert or remove writes the slot, and the result register
// is loaded.
// The result register parts the two channels: a new request is taken while
// a result still waits, but the following result is held back until the
// receiver has taken the earlier one.
// ============================================================================
module open_addressing_hash_table_unit #(
    parameter int SLOTS    = ohat_pkg::DEF_SLOTS,
    parameter int KEY_BITS = ohat_pkg::DEF_KEY_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ohat_pkg::REQ_BITS-1:0]      s_req_type,
    input  logic [ohat_pkg::KEY_W-1:0]         s_key,
    input  logic [ohat_pkg::PAY_BITS-1:0]      s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ohat_pkg::STATUS_BITS-1:0]   m_status,
    output logic [ohat_pkg::PAY_BITS-1:0]      m_value_out,
    output logic [ohat_pkg::SLOT_BITS-1:0]     m_slot,
    output logic [ohat_pkg::COUNT_BITS-1:0]    m_occupied,
    input  logic                               cfg_we,
    input  logic [ohat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ohat_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import ohat_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = $clog2(SLOTS + 1);
    localparam int WW = KEY_BITS + PAY_BITS + MARK_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [IW:0]            clr_reg, clr_next;
    logic [CFG_DATA_W-1:0]  tsize_reg, tsize_next;
    logic                   probe_reg, probe_next;
    logic                   hash_reg, hash_next;
    logic [REQ_BITS-1:0]    req_reg, req_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [PAY_BITS-1:0]    val_reg, val_next;
    logic [SW-1:0]          size_reg, size_next;
    logic [SW-1:0]          pos_reg, pos_next;
    logic [SW-1:0]          i_reg, i_next;
    logic [31:0]            frac_reg, frac_next;
    logic [SW-1:0]          count_reg, count_next;
    logic [STATUS_BITS-1:0] rst_reg, rst_next;
    logic [PAY_BITS-1:0]    rval_reg, rval_next;
    logic [SW-1:0]          rslot_reg, rslot_next;
    logic [WW-1:0]          wword_reg, wword_next;
    logic                   inc_reg, inc_next;
    logic                   mv_reg, mv_next;
    logic [STATUS_BITS-1:0] ms_reg, ms_next;
    logic [PAY_BITS-1:0]    mval_reg, mval_next;
    logic [SLOT_BITS-1:0]   mslot_reg, mslot_next;
    logic [COUNT_BITS-1:0]  mocc_reg, mocc_next;

    logic [16:0]         ts_ext, lsz_ext;
    logic [SW-1:0]       live_size;
    logic [KEY_BITS-1:0] key_in;
    logic                accept;
    logic                div_start, div_done;
    logic [SW-1:0]       div_rem;
    logic [SW+31:0]      hprod;
    logic [SW:0]         delta, dred, psum, pnext;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata, ram_rdata;
    logic [MARK_BITS-1:0] rd_mark;
    logic [KEY_BITS-1:0] rd_key;
    logic [PAY_BITS-1:0] rd_pay;
    logic                key_hit;

    assign ts_ext    = 17'(tsize_reg);
    assign lsz_ext   = (ts_ext == 17'd0) ? 17'd1 :
                       ((ts_ext > 17'(SLOTS)) ? 17'(SLOTS) : ts_ext);
    assign live_size = SW'(lsz_ext);
    assign key_in    = KEY_BITS'(s_key);
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign div_start = accept && !hash_reg && (s_req_type != REQ_UNKNOWN);

    assign hprod = {32'd0, size_reg} * {{SW{1'b0}}, frac_reg};

    assign rd_mark = ram_rdata[MARK_BITS-1:0];
    assign rd_pay  = ram_rdata[PAY_BITS+MARK_BITS-1:MARK_BITS];
    assign rd_key  = ram_rdata[WW-1:PAY_BITS+MARK_BITS];
    assign key_hit = (rd_mark == MARK_FULL) && (rd_key == key_reg);

    // Step from probe i to probe i + 1: in linear mode the position grows by one;
    // in quadratic mode the offset grows by i when i is even and by i + 2 when i is odd.
    always_comb begin
        if (!probe_reg) begin
            delta = (SW+1)'(1);
        end else if (i_reg[0]) begin
            delta = {1'b0, i_reg} + (SW+1)'(2);
        end else begin
            delta = {1'b0, i_reg};
        end
        dred  = (delta >= {1'b0, size_reg}) ? delta - {1'b0, size_reg} : delta;
        psum  = {1'b0, pos_reg} + dred;
        pnext = (psum >= {1'b0, size_reg}) ? psum - {1'b0, size_reg} : psum;
    end

    ohat_rem #(
        .KEY_BITS (KEY_BITS),
        .SW       (SW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (key_in),
        .divisor  (live_size),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg[IW-1:0] : pos_reg[IW-1:0];
    assign ram_wdata = (state_reg == S_CLEAR) ? {WW{1'b0}} : wword_reg;

    ohat_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pos_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        tsize_next = tsize_reg;
        probe_next = probe_reg;
        hash_next  = hash_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        i_next     = i_reg;
        frac_next  = frac_reg;
        count_next = count_reg;
        rst_next   = rst_reg;
        rval_next  = rval_reg;
        rslot_next = rslot_reg;
        wword_next = wword_reg;
        inc_next   = inc_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        mval_next  = mval_reg;
        mslot_next = mslot_reg;
        mocc_next  = mocc_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: tsize_next = cfg_wdata;
                CFG_PROBE_MODE: probe_next = cfg_wdata[0];
                CFG_HASH_MODE:  hash_next  = cfg_wdata[0];
                default: ;
            endcase
        end

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + (IW+1)'(1);
                if (clr_reg == (IW+1)'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_req_type;
                    key_next   = key_in;
                    val_next   = s_value;
                    size_next  = live_size;
                    i_next     = '0;
                    rst_next   = ST_MISS;
                    rval_next  = '0;
                    rslot_next = '0;
                    if (s_req_type == REQ_UNKNOWN) begin
                        state_next = S_DONE;
                    end else if (hash_reg) begin
                        state_next = S_MUL1;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    pos_next   = div_rem;
                    state_next = S_READ;
                end
            end
            S_MUL1: begin
                frac_next  = 32'(32'(key_reg) * GOLDEN_FRAC);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                pos_next   = hprod[SW+31:32];
                state_next = S_READ;
            end
            S_READ: begin
                if (i_reg == size_reg) begin
                    rst_next   = (req_reg == REQ_INSERT) ? ST_FULL : ST_MISS;
                    state_next = S_DONE;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = S_READ;
                pos_next   = SW'(pnext);
                i_next     = i_reg + SW'(1);
                if (req_reg == REQ_INSERT) begin
                    if (rd_mark != MARK_FULL) begin
                        wword_next = {key_reg, val_reg, MARK_FULL};
                        inc_next   = 1'b1;
                        pos_next   = pos_reg;
                        state_next = S_WRITE;
                    end
                end else if (rd_mark == MARK_EMPTY) begin
                    state_next = S_DONE;
                end else if (key_hit) begin
                    pos_next = pos_reg;
                    if (req_reg == REQ_FIND) begin
                        rst_next   = ST_OK;
                        rval_next  = rd_pay;
                        rslot_next = pos_reg;
                        state_next = S_DONE;
                    end else begin
                        wword_next = {key_reg, rd_pay, MARK_DELETED};
                        inc_next   = 1'b0;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                if (inc_reg) begin
                    count_next = count_reg + SW'(1);
                end else if (count_reg != '0) begin
                    count_next = count_reg - SW'(1);
                end
                rst_next   = ST_OK;
                rslot_next = pos_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = rst_reg;
                    mval_next  = rval_reg;
                    mslot_next = SLOT_BITS'(rslot_reg);
                    mocc_next  = COUNT_BITS'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            tsize_reg <= TABLE_SIZE_RESET;
            probe_reg <= 1'b0;
            hash_reg  <= 1'b0;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            tsize_reg <= tsize_next;
            probe_reg <= probe_next;
            hash_reg  <= hash_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
        req_reg   <= req_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        size_reg  <= size_next;
        pos_reg   <= pos_next;
        i_reg     <= i_next;
        frac_reg  <= frac_next;
        rst_reg   <= rst_next;
        rval_reg  <= rval_next;
        rslot_reg <= rslot_next;
        wword_reg <= wword_next;
        inc_reg   <= inc_next;
        ms_reg    <= ms_next;
        mval_reg  <= mval_next;
        mslot_reg <= mslot_next;
        mocc_reg  <= mocc_next;
    end

    assign m_valid     = mv_reg;
    assign m_status    = ms_reg;
    assign m_value_out = mval_reg;
    assign m_slot      = mslot_reg;
    assign m_occupied  = mocc_reg;

`ifndef NO_ASSERTIONS
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (pos_reg < size_reg))
        else $error("probe position outside the live table");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready) else $error("ready again straight after a beat");
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SW'(SLOTS)) else $error("full slot count exceeds the table");
    a_write_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |=> (state_reg == S_DONE && rst_reg == ST_OK))
        else $error("slot write not followed by a good result");
`endif

endmodule
